// ===== src/rpa_pkg.sv =====
// ============================================================================
// rpa_pkg
// Shared widths, command and status codes, and controller states for the
// reference-counted page allocator.
// ============================================================================
`timescale 1ns / 1ps

package rpa_pkg;

  // Fixed field widths of the channels
  localparam int ADDR_W   = 27;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int RCOUNT_W = 8;
  localparam int FREE_W   = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,   // post-reset sweep zeroing the count memory
    S_IDLE,    // waiting for a command word
    S_INIT,    // walking the pool, pushing pages
    S_EXEC     // read data back, modify, write, load result
  } rpa_state_t;

endpackage

// ===== src/rpa_if.sv =====
// ============================================================================
// rpa_if
// Valid/ready channel interfaces: command in, result out, configuration.
// ============================================================================
`timescale 1ns / 1ps

interface rpa_in_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, command, page_address, input ready);
  modport sink   (input valid, command, page_address, output ready);
endinterface

interface rpa_out_if import rpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_address;
  logic [RCOUNT_W-1:0] ref_count;
  logic [FREE_W-1:0]   free_pages;

  modport source (output valid, status, result_address, ref_count, free_pages,
                  input ready);
  modport sink   (input valid, status, result_address, ref_count, free_pages,
                  output ready);
endinterface

interface rpa_cfg_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/rpa_ram.sv =====
// ============================================================================
// rpa_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ============================================================================
`timescale 1ns / 1ps

module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rpa_ctrl.sv =====
// ============================================================================
// rpa_ctrl
// Command sequencer: decodes a command word, issues memory reads, then
// modifies and writes back the count and stack memories and loads the
// result register.
// ============================================================================
`timescale 1ns / 1ps

module rpa_ctrl import rpa_pkg::*; #(
  parameter int PAGE_COUNT  = 32768,
  parameter int PAGE_BYTES  = 4096,
  parameter int COUNT_WIDTH = 8,
  localparam int IDX_W = $clog2(PAGE_COUNT),
  localparam int CNT_W = COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  rpa_in_if.sink            in_chan,
  rpa_out_if.source         out_chan,
  rpa_cfg_if.sink           cfg_chan,
  // count memory
  output logic              cnt_we,
  output logic [IDX_W-1:0]  cnt_waddr,
  output logic [CNT_W-1:0]  cnt_wdata,
  output logic              cnt_re,
  output logic [IDX_W-1:0]  cnt_raddr,
  input  logic [CNT_W-1:0]  cnt_rdata,
  // stack memory
  output logic              stk_we,
  output logic [IDX_W-1:0]  stk_waddr,
  output logic [IDX_W-1:0]  stk_wdata,
  output logic              stk_re,
  output logic [IDX_W-1:0]  stk_raddr,
  input  logic [IDX_W-1:0]  stk_rdata
);

  localparam int DEP_W = $clog2(PAGE_COUNT + 1);
  localparam int SH    = $clog2(PAGE_BYTES);
  localparam int PN_W  = ADDR_W - SH;        // page number taken from an address
  localparam int FST_W = ADDR_W + 1 - SH;    // rounded-up kernel end page
  localparam int CMP_W = ((PN_W > FST_W) ? PN_W : FST_W) > DEP_W ?
                         ((PN_W > FST_W) ? PN_W : FST_W) : DEP_W;

  rpa_state_t state_r, state_nxt;

  logic [IDX_W-1:0]    walk_r, walk_nxt;
  logic [DEP_W-1:0]    depth_r, depth_nxt;
  logic [ADDR_W-1:0]   kend_r;
  logic                out_valid_r, out_valid_nxt;

  // latched command word
  logic [CMD_W-1:0]    cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [IDX_W-1:0]    pidx_r;
  logic                range_r;
  logic                free_bad_r;

  // result register
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [RCOUNT_W-1:0] rcount_r, rcount_nxt;
  logic [FREE_W-1:0]   free_r, free_nxt;

  logic                in_ready;
  logic                in_acc;
  logic                out_free;
  logic                commit;
  logic                last_page;
  logic                init_has_pages;

  logic [PN_W-1:0]     in_pn;
  logic                in_range;
  logic                in_free_bad;
  logic [ADDR_W:0]     kend_sum;
  logic [FST_W-1:0]    first_page;

  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W-1:0]    cnt_inc;
  logic                stack_empty;
  logic                stack_full;

  // --------------------------------------------------------------------------
  // Decode of the incoming word and of the init range
  // --------------------------------------------------------------------------
  assign in_pn       = in_chan.page_address[ADDR_W-1:SH];
  assign in_range    = CMP_W'(in_pn) < CMP_W'(PAGE_COUNT);
  assign in_free_bad = !in_range || (in_chan.page_address[SH-1:0] != '0) ||
                       (in_chan.page_address < kend_r);

  assign kend_sum       = (ADDR_W+1)'(kend_r) + (ADDR_W+1)'(PAGE_BYTES - 1);
  assign first_page     = kend_sum[ADDR_W:SH];
  assign init_has_pages = CMP_W'(first_page) < CMP_W'(PAGE_COUNT);

  assign in_acc    = in_chan.valid && in_ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign last_page = (walk_r == IDX_W'(PAGE_COUNT - 1));

  assign cnt_dec     = cnt_rdata - CNT_W'(1);
  assign cnt_inc     = cnt_rdata + CNT_W'(1);
  assign stack_empty = (depth_r == '0);
  assign stack_full  = (depth_r == DEP_W'(PAGE_COUNT));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (last_page) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.command == CMD_INIT && init_has_pages) state_nxt = S_INIT;
          else state_nxt = S_EXEC;
        end
      end
      S_INIT: begin
        if (last_page) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: handshakes, memory ports, read-modify-write and result
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready      = 1'b0;
    commit        = 1'b0;
    cnt_we        = 1'b0;
    cnt_waddr     = pidx_r;
    cnt_wdata     = '0;
    cnt_re        = 1'b0;
    cnt_raddr     = IDX_W'(in_pn);
    stk_we        = 1'b0;
    stk_waddr     = IDX_W'(depth_r);
    stk_wdata     = pidx_r;
    stk_re        = 1'b0;
    stk_raddr     = IDX_W'(depth_r - DEP_W'(1));
    walk_nxt      = walk_r;
    depth_nxt     = depth_r;
    status_nxt    = ST_OK;
    res_addr_nxt  = addr_r;
    rcount_nxt    = '0;
    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = walk_r;
        walk_nxt  = walk_r + IDX_W'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cnt_re = 1'b1;
          stk_re = (in_chan.command == CMD_ALLOC) && !stack_empty;
          if (in_chan.command == CMD_INIT) begin
            depth_nxt = '0;
            walk_nxt  = IDX_W'(first_page);
          end
        end
      end
      S_INIT: begin
        // push walk_r and zero its count
        cnt_we    = 1'b1;
        cnt_waddr = walk_r;
        stk_we    = 1'b1;
        stk_wdata = walk_r;
        depth_nxt = depth_r + DEP_W'(1);
        walk_nxt  = walk_r + IDX_W'(1);
      end
      S_EXEC: begin
        commit = out_free;
        case (cmd_r)
          CMD_ALLOC: begin
            if (stack_empty) begin
              status_nxt   = ST_EMPTY;
              res_addr_nxt = '0;
            end else begin
              cnt_we       = commit;
              cnt_waddr    = stk_rdata;
              cnt_wdata    = CNT_W'(1);
              depth_nxt    = commit ? depth_r - DEP_W'(1) : depth_r;
              res_addr_nxt = ADDR_W'({stk_rdata, {SH{1'b0}}});
              rcount_nxt   = RCOUNT_W'(1);
            end
          end
          CMD_FREE: begin
            if (free_bad_r) begin
              status_nxt = ST_BAD_ADDR;
            end else if (cnt_rdata == '0) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              cnt_we     = commit;
              cnt_wdata  = cnt_dec;
              rcount_nxt = RCOUNT_W'(cnt_dec);
              // last reference gone: page goes back on the stack unless the stack is full
              if (cnt_dec == '0 && !stack_full) begin
                stk_we    = commit;
                depth_nxt = commit ? depth_r + DEP_W'(1) : depth_r;
              end
            end
          end
          CMD_ADD: begin
            if (!range_r) begin
              status_nxt = ST_BAD_ADDR;
            end else if (cnt_rdata == '1) begin
              status_nxt = ST_OVERFLOW;
              rcount_nxt = RCOUNT_W'(cnt_rdata);
            end else begin
              cnt_we     = commit;
              cnt_wdata  = cnt_inc;
              rcount_nxt = RCOUNT_W'(cnt_inc);
            end
          end
          CMD_DROP: begin
            if (!range_r) begin
              status_nxt = ST_BAD_ADDR;
            end else if (cnt_rdata == '0) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              cnt_we     = commit;
              cnt_wdata  = cnt_dec;
              rcount_nxt = RCOUNT_W'(cnt_dec);
            end
          end
          CMD_INIT: begin
            rcount_nxt = '0;
          end
          default: begin
            // unused codes only report the count
            rcount_nxt = range_r ? RCOUNT_W'(cnt_rdata) : '0;
          end
        endcase
      end
      default: ;
    endcase
    free_nxt = FREE_W'(depth_nxt);
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      walk_r      <= '0;
      depth_r     <= '0;
      kend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) kend_r <= cfg_chan.data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r      <= in_chan.command;
      addr_r     <= in_chan.page_address;
      pidx_r     <= IDX_W'(in_pn);
      range_r    <= in_range;
      free_bad_r <= in_free_bad;
    end
    if (commit) begin
      status_r   <= status_nxt;
      res_addr_r <= res_addr_nxt;
      rcount_r   <= rcount_nxt;
      free_r     <= free_nxt;
    end
  end

  assign in_chan.ready           = in_ready;
  assign cfg_chan.ready          = 1'b1;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = status_r;
  assign out_chan.result_address = res_addr_r;
  assign out_chan.ref_count      = rcount_r;
  assign out_chan.free_pages     = free_r;

endmodule

// ===== src/refcounted_page_allocator.sv =====
// ============================================================================
// refcounted_page_allocator
// Page pool with a LIFO free stack and per-page reference counts, both held
// in synchronous RAMs with registered read data.
// ============================================================================
//  channel    dir  handshake      word
//  in_chan    in   valid/ready    command, page_address
//  out_chan   out  valid/ready    status, result_address, ref_count, free_pages
//  cfg_chan   in   valid/ready    data (kernel end offset)
//
//  Alloc, free, add, drop and unused codes: the S_IDLE accept reads the count
//  RAM (and the stack RAM for alloc), S_EXEC writes back and loads the result
//  register. Init walks S_INIT from first_page to the last page, writing both
//  RAMs per page. After reset a clear sweep zeroes the count RAM, no command
//  word accepted meanwhile (cfg writes are always accepted).
//  A held result stalls write-back; one new word may be taken while it waits.
// ============================================================================
`timescale 1ns / 1ps

module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int PAGE_COUNT  = 32768,
  parameter int PAGE_BYTES  = 4096,
  parameter int COUNT_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  rpa_in_if.sink    in_chan,
  rpa_out_if.source out_chan,
  rpa_cfg_if.sink   cfg_chan
);

  localparam int IDX_W = $clog2(PAGE_COUNT);

  logic                   cnt_we, cnt_re;
  logic [IDX_W-1:0]       cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic                   stk_we, stk_re;
  logic [IDX_W-1:0]       stk_waddr, stk_raddr;
  logic [IDX_W-1:0]       stk_wdata, stk_rdata;

  // Sequencer
  rpa_ctrl #(
    .PAGE_COUNT  (PAGE_COUNT),
    .PAGE_BYTES  (PAGE_BYTES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_chan  (cfg_chan),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_re    (cnt_re),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_re    (stk_re),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // Reference count RAM
  rpa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (PAGE_COUNT)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Free stack RAM
  rpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PAGE_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

// ===== tb/sv/tb_refcounted_page_allocator.sv =====
// ============================================================================
// tb_refcounted_page_allocator
// Self-checking bench for the reference-counted page allocator. A tracker
// class keeps its own free stack and count table, predicts one result word
// per command word and checks each result word in order. A directed opener
// hits the pool extremes, then small random pools with pumped counts,
// while both channels idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module tb_refcounted_page_allocator import rpa_pkg::*; ();

  localparam int PAGE_COUNT   = 32768;
  localparam int PAGE_BYTES   = 4096;
  localparam int COUNT_WIDTH  = 8;
  localparam int PAGE_IDX_W   = $clog2(PAGE_COUNT);
  localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
  localparam int STATUS_KINDS = 5;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASE_ITEMS  = 150;
  localparam int SHORT_POOL   = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  // command codes with no defined operation
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;
    logic [RCOUNT_W-1:0] ref_count;
    logic [FREE_W-1:0]   free_pages;
  } pool_result_t;

  // --------------------------------------------------------------------------
  // Pool tracker: shadow stack and counts, queue of predicted result words
  // --------------------------------------------------------------------------
  class page_pool_tracker;
    logic [PAGE_IDX_W-1:0] stack_pages [PAGE_COUNT];
    logic [RCOUNT_W-1:0]   page_refs   [PAGE_COUNT];
    int unsigned           stack_top;
    logic [ADDR_W-1:0]     kernel_end;
    pool_result_t          pending_results [$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           status_hits [STATUS_KINDS];

    function new();
      foreach (page_refs[i]) page_refs[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      stack_top  = 0;
      kernel_end = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // push is dropped once the stack holds the whole pool
    function void push_free(int unsigned pg);
      if (stack_top < PAGE_COUNT) begin
        stack_pages[stack_top] = PAGE_IDX_W'(pg);
        stack_top++;
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
      pool_result_t r;
      int unsigned  pg;
      int unsigned  first;
      logic         in_pool;
      r.status         = ST_OK;
      r.result_address = addr;
      r.ref_count      = '0;
      pg      = addr / PAGE_BYTES;
      in_pool = (pg < PAGE_COUNT);
      case (cmd)
        CMD_ALLOC: begin
          if (stack_top == 0) begin
            r.status         = ST_EMPTY;
            r.result_address = '0;
          end else begin
            stack_top--;
            pg = stack_pages[stack_top];
            page_refs[pg]    = RCOUNT_W'(1);
            r.result_address = ADDR_W'(pg * PAGE_BYTES);
            r.ref_count      = RCOUNT_W'(1);
          end
        end
        CMD_FREE: begin
          if (!in_pool || (addr % PAGE_BYTES) != 0 || addr < kernel_end) begin
            r.status = ST_BAD_ADDR;
          end else if (page_refs[pg] == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            page_refs[pg]--;
            r.ref_count = page_refs[pg];
            if (page_refs[pg] == 0) push_free(pg);
          end
        end
        CMD_ADD, CMD_DROP: begin
          // no alignment or kernel-end check here
          if (!in_pool) begin
            r.status = ST_BAD_ADDR;
          end else begin
            if (cmd == CMD_ADD) begin
              if (page_refs[pg] >= COUNT_MAX) r.status = ST_OVERFLOW;
              else page_refs[pg]++;
            end else begin
              if (page_refs[pg] == 0) r.status = ST_UNDERFLOW;
              else page_refs[pg]--;
            end
            r.ref_count = page_refs[pg];
          end
        end
        CMD_INIT: begin
          first = (kernel_end + PAGE_BYTES - 1) / PAGE_BYTES;
          stack_top = 0;
          for (int unsigned p = first; p < PAGE_COUNT; p++) begin
            page_refs[p] = '0;
            push_free(p);
          end
        end
        default: begin
          if (in_pool) r.ref_count = page_refs[pg];
        end
      endcase
      r.free_pages = FREE_W'(stack_top);
      pending_results.push_back(r);
    endfunction

    task check_result(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] ra,
                      logic [RCOUNT_W-1:0] rc, logic [FREE_W-1:0] fp);
      pool_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with nothing pending: status %0d addr 0x%07h",
                         st, ra));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (st < STATUS_KINDS) status_hits[st]++;
      if (st !== want.status)
        report($sformatf("word %0d status: got %0d, want %0d", checked, st, want.status));
      if (ra !== want.result_address)
        report($sformatf("word %0d result_address: got 0x%07h, want 0x%07h",
                         checked, ra, want.result_address));
      if (rc !== want.ref_count)
        report($sformatf("word %0d ref_count: got %0d, want %0d",
                         checked, rc, want.ref_count));
      if (fp !== want.free_pages)
        report($sformatf("word %0d free_pages: got %0d, want %0d",
                         checked, fp, want.free_pages));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  rpa_in_if  in_bus ();
  rpa_out_if out_bus ();
  rpa_cfg_if cfg_bus ();

  refcounted_page_allocator #(
    .PAGE_COUNT  (PAGE_COUNT),
    .PAGE_BYTES  (PAGE_BYTES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  page_pool_tracker sb = new();

  int unsigned       burst_left     = 0;
  int unsigned       sent_count     = 0;
  int unsigned       random_sent    = 0;
  int unsigned       cfg_writes     = 0;
  int unsigned       hold_asks      = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       win_first      = 0;
  logic [ADDR_W-1:0] kernel_end_now = '0;

  // --------------------------------------------------------------------------
  // Monitor: every handshake sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.kernel_end = cfg_bus.data;
      if (in_bus.valid && in_bus.ready)
        sb.note_command(in_bus.command, in_bus.page_address);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.status, out_bus.result_address,
                        out_bus.ref_count, out_bus.free_pages);
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall pattern changes at random; a hold
  // request closes it for a long stretch
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    int unsigned mode;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    mode      = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] page_base(int unsigned pg);
    return ADDR_W'(pg * PAGE_BYTES);
  endfunction

  // one command word; bursts of random length with random gaps between
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid        <= 1'b1;
    in_bus.command      <= c;
    in_bus.page_address <= a;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_count++;
  endtask

  // sender pauses until every predicted result word has come back
  task automatic idle_until_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic write_kernel_end(input logic [ADDR_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    kernel_end_now = v;
    win_first      = (v + PAGE_BYTES - 1) / PAGE_BYTES;
    cfg_writes++;
  endtask

  // mostly pages of the managed window, some anywhere, some raw offsets
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 65 && win_first < PAGE_COUNT)
      return page_base($urandom_range(PAGE_COUNT - 1, win_first));
    if (sel < 78) return page_base($urandom_range(PAGE_COUNT - 1, 0));
    if (sel < 84) return kernel_end_now;
    return ADDR_W'($urandom());
  endfunction

  task automatic send_random_word();
    int unsigned      sel;
    logic [CMD_W-1:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 32)      c = CMD_ALLOC;
    else if (sel < 57) c = CMD_FREE;
    else if (sel < 77) c = CMD_ADD;
    else if (sel < 93) c = CMD_DROP;
    else if (sel < 96)
      c = CMD_W'(CMD_SPARE_FIRST + $urandom_range(0, CMD_SPARE_LAST - CMD_SPARE_FIRST));
    else if (PAGE_COUNT - win_first <= SHORT_POOL) c = CMD_INIT;
    else               c = CMD_ALLOC;
    send_word(c, pick_address());
    random_sent++;
  endtask

  // drive one page's count up into overflow, back down, then free it
  task automatic pump_counts();
    logic [ADDR_W-1:0] a;
    int unsigned       drops;
    a = (win_first < PAGE_COUNT) ? page_base($urandom_range(PAGE_COUNT - 1, win_first))
                                 : pick_address();
    repeat (COUNT_MAX + $urandom_range(1, 3)) begin
      send_word(CMD_ADD, a);
      random_sent++;
    end
    drops = $urandom_range(COUNT_MAX + 3, COUNT_MAX - 40);
    repeat (drops) begin
      send_word(CMD_DROP, a);
      random_sent++;
    end
    send_word(CMD_FREE, a);
    random_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d result words pending",
             cycle_count, sb.pending_results.size());
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned       ph;
    int unsigned       sel;
    int unsigned       first;
    logic [ADDR_W-1:0] ke;
    in_bus.valid        <= 1'b0;
    in_bus.command      <= CMD_ALLOC;
    in_bus.page_address <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.data        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // whole pool managed: full stack, dropped push, edge addresses
    write_kernel_end('0);
    send_word(CMD_INIT, ADDR_TOP);
    send_word(CMD_ADD, page_base(5));
    send_word(CMD_FREE, page_base(5));
    send_word(CMD_ALLOC, ADDR_TOP);
    send_word(CMD_FREE, page_base(PAGE_COUNT - 1));
    send_word(CMD_FREE, ADDR_W'(page_base(5) + 1));
    send_word(CMD_DROP, page_base(6));
    send_word(CMD_ADD, ADDR_TOP);
    send_word(CMD_DROP, ADDR_TOP);
    send_word(CMD_SPARE_FIRST, '0);
    send_word(CMD_SPARE_LAST, ADDR_TOP);

    // kernel end past the pool: empty stack
    idle_until_drained();
    write_kernel_end(ADDR_TOP);
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, ADDR_TOP);
    send_word(CMD_FREE, '0);
    send_word(CMD_ADD, '0);

    // two-page pool: drain it, refill it, reject below the kernel end
    idle_until_drained();
    write_kernel_end(page_base(PAGE_COUNT - 2));
    send_word(CMD_INIT, '0);
    send_word(CMD_FREE, kernel_end_now);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ADD, page_base(PAGE_COUNT - 2));
    send_word(CMD_FREE, page_base(PAGE_COUNT - 2));
    send_word(CMD_FREE, page_base(PAGE_COUNT - 2));
    send_word(CMD_FREE, page_base(PAGE_COUNT - 3));

    // random phases, each with its own kernel end
    ph = 0;
    while (random_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (ph == 3) begin
        ke = ADDR_W'($urandom_range(ADDR_TOP, 0));
      end else if (sel == 0) begin
        ke = ADDR_W'($urandom_range(ADDR_TOP, page_base(PAGE_COUNT - 1) + 1));
      end else begin
        first = PAGE_COUNT - $urandom_range(48, 1);
        ke = page_base(first);
        if (sel > 4) ke = ke - ADDR_W'($urandom_range(PAGE_BYTES - 1, 0));
      end
      idle_until_drained();
      write_kernel_end(ke);
      send_word(CMD_INIT, pick_address());
      // long receiver hold while the sender keeps offering
      if (ph == 1) hold_asks <= hold_asks + 1;
      if (ph % 3 == 0) pump_counts();
      repeat (PHASE_ITEMS) send_random_word();
      ph++;
    end

    idle_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending_results.size()));

    $display("Run: %0d command words (%0d random) over %0d kernel-end settings, %0d results",
             sent_count, random_sent, cfg_writes, sb.checked);
    $display("Status mix: ok %0d, empty %0d, bad address %0d, underflow %0d, overflow %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY], sb.status_hits[ST_BAD_ADDR],
             sb.status_hits[ST_UNDERFLOW], sb.status_hits[ST_OVERFLOW]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rpa_pkg.sv
src/rpa_if.sv
src/rpa_ram.sv
src/rpa_ctrl.sv
src/refcounted_page_allocator.sv
tb/sv/tb_refcounted_page_allocator.sv
